// File: rtl/matrix4_inverse_cofactor_assert.svh
// Assertion macros for the 4x4 matrix inverse block.
// Included by the top level; no other dependencies.
`ifndef MATRIX4_INVERSE_COFACTOR_ASSERT_SVH
`define MATRIX4_INVERSE_COFACTOR_ASSERT_SVH
`define M4I_ASSERT_IMPL(lbl, a, c) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
        else $error("assertion failed");
`define M4I_ASSERT_NEXT(lbl, a, c) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
        else $error("assertion failed");
`endif

// File: rtl/m4inv_pkg.sv
// Package for the 4x4 matrix inverse block: widths and shared types.
// No dependencies.
package m4inv_pkg;
    localparam int ElemW = 15;
    localparam int CofW  = 49;
    localparam int DetW  = 61;
    localparam int OutW  = 32;
    typedef logic signed [ElemW-1:0] elem_t;
    typedef logic signed [CofW-1:0]  cof_t;
    typedef logic signed [DetW-1:0]  det_t;
    typedef struct packed {
        logic       start;
        logic       busy;
        logic       done;
    } div_ctl_t;
endpackage

// File: rtl/matrix4_inverse_cofactor.sv
// Usage: 4x4 matrix inverse by cofactors and adjugate, fixed point.
// Input s_axis: one matrix element per item, tagged with its index (row*4+col).
// Index 15 stores its element and starts a run; other indices only store.
// Output m_axis: 16 inverse elements in index order, tlast on index 15.
// A zero determinant gives a single item with the singular flag and tlast.
// Each cofactor sums 6 terms of three factors read from the matrix memory
// and is then written to the cofactor memory; after all 16 cofactors come
// the determinant and its zero check, then per result one bit-serial
// division.
// Items are accepted whenever the block is loading; a run blocks input until its last
// result is registered.
// Reset clears the matrix memory in a pass over all 16 entries; s_axis_tready stays low
// meanwhile. A stalled receiver holds the output register and the run waits.
// Depends on m4inv_pkg, m4inv_core, m4inv_div and the assertion header.
module matrix4_inverse_cofactor #(
    parameter int FRACTION_BITS = 10
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [23:0] s_axis_tdata,   // element_index[3:0], element_value[18:4]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [39:0] m_axis_tdata,   // out_index[3:0], out_value[35:4]
    output logic [1:0]  m_axis_tuser,   // singular[0], saturated[1]
    output logic        m_axis_tlast
);
    import m4inv_pkg::*;
`include "matrix4_inverse_cofactor_assert.svh"

    logic [31:0] val;
    logic [3:0]  idx;
    logic        sing, sat;

    m4inv_core #(.FRACTION_BITS(FRACTION_BITS)) u_core (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid && s_axis_tready),
        .in_ready (s_axis_tready),
        .in_idx   (s_axis_tdata[3:0]),
        .in_val   (elem_t'(s_axis_tdata[18:4])),
        .res_valid(m_axis_tvalid),
        .res_ready(m_axis_tready),
        .res_idx  (idx),
        .res_val  (val),
        .res_sing (sing),
        .res_sat  (sat),
        .res_last (m_axis_tlast)
    );

    assign m_axis_tdata = {4'd0, val, idx};
    assign m_axis_tuser = {sat, sing};

    `M4I_ASSERT_IMPL(a_sing_last, m_axis_tvalid && m_axis_tuser[0], m_axis_tlast)
    `M4I_ASSERT_IMPL(a_sing_nosat, m_axis_tvalid && m_axis_tuser[0], !m_axis_tuser[1])
    `M4I_ASSERT_IMPL(a_busy_out, m_axis_tvalid && !m_axis_tlast, !s_axis_tready)
endmodule

// File: rtl/m4inv_div.sv
// Sequential signed divider: trunc(num * 2^shift / den) saturated to 32 bits.
// Depends on m4inv_pkg.
module m4inv_div #(
    parameter int SHIFT = 20
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      start,
    input  m4inv_pkg::cof_t           num,
    input  m4inv_pkg::det_t           den,
    output logic                      done,
    output logic [31:0]               quo,
    output logic                      sat
);
    import m4inv_pkg::*;
    localparam int NW  = CofW + SHIFT;
    localparam int CW  = $clog2(NW + 1);
    localparam logic [CW-1:0] NWC = CW'(NW);

    logic [NW-1:0]   n_reg;
    logic [DetW-1:0] d_reg;
    logic [DetW:0]   r_reg;
    logic [32:0]     q_reg;
    logic            neg_reg, run_reg, done_reg;
    logic [CW-1:0]   cnt_reg;
    logic [DetW:0]   r_sh, r_sub;
    logic [32:0]     q_sh;
    logic            ge;
    logic [CofW-1:0] nm;
    logic [DetW-1:0] dm;

    assign nm = num[CofW-1] ? CofW'(-num) : CofW'(num);
    assign dm = den[DetW-1] ? DetW'(-den) : DetW'(den);
    assign r_sh  = {r_reg[DetW-1:0], n_reg[NW-1]};
    assign ge    = r_sh >= {1'b0, d_reg};
    assign r_sub = ge ? r_sh - {1'b0, d_reg} : r_sh;
    assign q_sh  = q_reg[32] ? q_reg : {q_reg[31:0], ge};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                run_reg <= 1'b1;
                cnt_reg <= '0;
            end
            else if (run_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == NWC - 1'b1)
                begin
                    run_reg  <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            n_reg   <= NW'(nm) << SHIFT;
            d_reg   <= dm;
            r_reg   <= '0;
            q_reg   <= '0;
            neg_reg <= num[CofW-1] ^ den[DetW-1];
        end
        else if (run_reg)
        begin
            n_reg <= {n_reg[NW-2:0], 1'b0};
            r_reg <= r_sub;
            q_reg <= q_sh;
        end
    end

    always_comb
    begin
        sat = 1'b0;
        if (!neg_reg)
        begin
            if (q_reg > 33'h07FFFFFFF)
            begin
                sat = 1'b1;
                quo = 32'h7FFFFFFF;
            end
            else
                quo = q_reg[31:0];
        end
        else
        begin
            if (q_reg > 33'h080000000)
            begin
                sat = 1'b1;
                quo = 32'h80000000;
            end
            else
                quo = 32'(33'd0 - q_reg);
        end
    end
    assign done = done_reg;
endmodule

// File: rtl/m4inv_core.sv
// Memory-centered sequencer: matrix and cofactor memories, multipliers and a divider.
// Depends on m4inv_pkg and m4inv_div.
module m4inv_core #(
    parameter int FRACTION_BITS = 10
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic [3:0]           in_idx,
    input  m4inv_pkg::elem_t     in_val,
    output logic                 res_valid,
    input  logic                 res_ready,
    output logic [3:0]           res_idx,
    output logic [31:0]          res_val,
    output logic                 res_sing,
    output logic                 res_sat,
    output logic                 res_last
);
    import m4inv_pkg::*;

    localparam logic [3:0] S_LOAD  = 4'd0;
    localparam logic [3:0] S_CLR   = 4'd1;
    localparam logic [3:0] S_RDA   = 4'd2;
    localparam logic [3:0] S_RDB   = 4'd3;
    localparam logic [3:0] S_MUL1  = 4'd4;
    localparam logic [3:0] S_MUL2  = 4'd5;
    localparam logic [3:0] S_ACC   = 4'd6;
    localparam logic [3:0] S_CWR   = 4'd7;
    localparam logic [3:0] S_DRD   = 4'd8;
    localparam logic [3:0] S_DACC  = 4'd9;
    localparam logic [3:0] S_QRD   = 4'd10;
    localparam logic [3:0] S_QST   = 4'd11;
    localparam logic [3:0] S_QWT   = 4'd12;
    localparam logic [3:0] S_OUT   = 4'd13;
    localparam logic [3:0] S_CHK   = 4'd14;

    logic [3:0]  st_reg;
    logic [3:0]  clr_reg;
    logic [3:0]  k_reg;      // adjugate entry
    logic [2:0]  t_reg;      // term 0..5
    logic [1:0]  f_reg;      // factor 0..2
    logic signed [ElemW-1:0] mem_m [16];
    logic signed [CofW-1:0]  mem_c [16];
    logic signed [ElemW-1:0] m_rd_reg;
    logic signed [CofW-1:0]  c_rd_reg;
    logic signed [ElemW-1:0] fa_reg;
    logic signed [2*ElemW-1:0] p2_reg;
    logic signed [CofW-1:0]  acc_reg;
    det_t                    det_reg;
    logic [3:0]  m_addr;
    logic        m_we;
    logic [3:0]  m_wa;
    elem_t       m_wd;

    // term permutations over three rows/cols: (c0,c1,c2) and sign
    logic [1:0] pc0, pc1, pc2;
    logic       pneg;
    always_comb
    begin
        unique case (t_reg)
            3'd0: begin pc0 = 2'd0; pc1 = 2'd1; pc2 = 2'd2; pneg = 1'b0; end
            3'd1: begin pc0 = 2'd0; pc1 = 2'd2; pc2 = 2'd1; pneg = 1'b1; end
            3'd2: begin pc0 = 2'd1; pc1 = 2'd0; pc2 = 2'd2; pneg = 1'b1; end
            3'd3: begin pc0 = 2'd1; pc1 = 2'd2; pc2 = 2'd0; pneg = 1'b0; end
            3'd4: begin pc0 = 2'd2; pc1 = 2'd0; pc2 = 2'd1; pneg = 1'b0; end
            default: begin pc0 = 2'd2; pc1 = 2'd1; pc2 = 2'd0; pneg = 1'b1; end
        endcase
    end

    // adjugate entry k=(r,c) is cofactor of element (c,r): drop row c, col r
    logic [1:0] drow, dcol, sub_r, sub_c, colsel;
    logic [1:0] rr, cc;
    assign drow = k_reg[1:0];
    assign dcol = k_reg[3:2];
    assign sub_r = 2'(f_reg);
    always_comb
    begin
        unique case (f_reg)
            2'd0:    colsel = pc0;
            2'd1:    colsel = pc1;
            default: colsel = pc2;
        endcase
    end
    assign sub_c = colsel;
    assign rr = (sub_r >= drow) ? sub_r + 2'd1 : sub_r;
    assign cc = (sub_c >= dcol) ? sub_c + 2'd1 : sub_c;

    always_comb
    begin
        m_we = 1'b0;
        m_wa = in_idx;
        m_wd = in_val;
        if (st_reg == S_CLR)
        begin
            m_we = 1'b1;
            m_wa = clr_reg;
            m_wd = '0;
        end
        else if (st_reg == S_LOAD && in_valid)
            m_we = 1'b1;
        if (st_reg == S_DRD)
            m_addr = {2'd0, k_reg[3:2]};
        else
            m_addr = {rr, cc};
    end

    always_ff @(posedge clk)
    begin
        if (m_we)
            mem_m[m_wa] <= m_wd;
        m_rd_reg <= mem_m[m_addr];
    end

    logic [3:0]  c_addr;
    logic        c_we;
    assign c_we = (st_reg == S_CWR);
    always_ff @(posedge clk)
    begin
        if (c_we)
            mem_c[k_reg] <= ((k_reg[0] ^ k_reg[2]) ? -acc_reg : acc_reg);
        c_rd_reg <= mem_c[c_addr];
    end
    assign c_addr = k_reg;

    // divider
    logic        dv_start, dv_done, dv_sat;
    logic [31:0] dv_quo;
    m4inv_div #(.SHIFT(2 * FRACTION_BITS)) u_div (
        .clk  (clk),
        .rst_n(rst_n),
        .start(dv_start),
        .num  (c_rd_reg),
        .den  (det_reg),
        .done (dv_done),
        .quo  (dv_quo),
        .sat  (dv_sat)
    );
    assign dv_start = (st_reg == S_QST);

    logic        ov_reg, sing_reg, sat_o_reg, last_o_reg;
    logic [3:0]  idx_o_reg;
    logic [31:0] val_o_reg;
    logic signed [CofW-1:0] p3;
    logic signed [DetW-1:0] dprod;
    assign p3 = CofW'(p2_reg) * CofW'(m_rd_reg);
    assign dprod = DetW'(m_rd_reg) * DetW'(c_rd_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg  <= S_CLR;
            clr_reg <= '0;
            k_reg   <= '0;
            t_reg   <= '0;
            f_reg   <= '0;
            ov_reg  <= 1'b0;
            det_reg <= '0;
        end
        else
        begin
            if (ov_reg && res_ready)
                ov_reg <= 1'b0;
            unique case (st_reg)
                S_CLR:
                begin
                    clr_reg <= clr_reg + 4'd1;
                    if (clr_reg == 4'd15)
                        st_reg <= S_LOAD;
                end
                S_LOAD:
                    if (in_valid && in_idx == 4'd15)
                    begin
                        st_reg  <= S_RDA;
                        k_reg   <= '0;
                        t_reg   <= '0;
                        f_reg   <= '0;
                        acc_reg <= '0;
                    end
                S_RDA:
                begin
                    f_reg  <= 2'd1;
                    st_reg <= S_RDB;
                end
                S_RDB:
                begin
                    fa_reg <= m_rd_reg;
                    f_reg  <= 2'd2;
                    st_reg <= S_MUL1;
                end
                S_MUL1:
                begin
                    p2_reg <= fa_reg * m_rd_reg;
                    st_reg <= S_MUL2;
                end
                S_MUL2:
                    st_reg <= S_ACC;
                S_ACC:
                begin
                    acc_reg <= pneg ? acc_reg - p3 : acc_reg + p3;
                    f_reg   <= '0;
                    if (t_reg == 3'd5)
                        st_reg <= S_CWR;
                    else
                    begin
                        t_reg  <= t_reg + 3'd1;
                        st_reg <= S_RDA;
                    end
                end
                S_CWR:
                begin
                    t_reg   <= '0;
                    acc_reg <= '0;
                    if (k_reg == 4'd15)
                    begin
                        k_reg   <= '0;
                        det_reg <= '0;
                        st_reg  <= S_DRD;
                    end
                    else
                    begin
                        k_reg  <= k_reg + 4'd1;
                        st_reg <= S_RDA;
                    end
                end
                S_DRD:
                    st_reg <= S_DACC;
                S_DACC:
                begin
                    det_reg <= det_reg + dprod;
                    if (k_reg == 4'd12)
                    begin
                        k_reg  <= '0;
                        st_reg <= S_CHK;
                    end
                    else
                    begin
                        k_reg  <= k_reg + 4'd4;
                        st_reg <= S_DRD;
                    end
                end
                S_CHK:
                    if (det_reg == '0)
                    begin
                        if (!ov_reg)
                        begin
                            ov_reg     <= 1'b1;
                            idx_o_reg  <= '0;
                            val_o_reg  <= '0;
                            sing_reg   <= 1'b1;
                            sat_o_reg  <= 1'b0;
                            last_o_reg <= 1'b1;
                            st_reg     <= S_LOAD;
                        end
                    end
                    else
                        st_reg <= S_QRD;
                S_QRD:
                    st_reg <= S_QST;
                S_QST:
                    st_reg <= S_QWT;
                S_QWT:
                    if (dv_done)
                        st_reg <= S_OUT;
                S_OUT:
                    if (!ov_reg || res_ready)
                    begin
                        ov_reg     <= 1'b1;
                        idx_o_reg  <= k_reg;
                        val_o_reg  <= dv_quo;
                        sing_reg   <= 1'b0;
                        sat_o_reg  <= dv_sat;
                        last_o_reg <= (k_reg == 4'd15);
                        if (k_reg == 4'd15)
                            st_reg <= S_LOAD;
                        else
                        begin
                            k_reg  <= k_reg + 4'd1;
                            st_reg <= S_QRD;
                        end
                    end
                default:
                    st_reg <= S_LOAD;
            endcase
        end
    end

    assign in_ready  = (st_reg == S_LOAD);
    assign res_valid = ov_reg;
    assign res_idx   = idx_o_reg;
    assign res_val   = val_o_reg;
    assign res_sing  = sing_reg;
    assign res_sat   = sat_o_reg;
    assign res_last  = last_o_reg;
endmodule

// File: tb/sv/matrix4_inverse_cofactor_tb.sv
// Testbench for matrix4_inverse_cofactor: directed and random 4x4 matrices in, inverse out.
// Expected inverse elements come from a local cofactor/adjugate predictor with 128-bit division.
// Depends on m4inv_pkg and the matrix4_inverse_cofactor RTL.
`timescale 1ns / 100ps

module matrix4_inverse_cofactor_tb;
    import m4inv_pkg::*;

    localparam int FracBits = 10;
    localparam int LastIdx  = 15;

    typedef struct {
        logic [3:0]  idx;
        logic [31:0] value;
        logic        singular;
        logic        saturated;
        logic        last;
    } inv_elem_t;

    logic        clk;
    logic        rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [23:0] s_axis_tdata;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [39:0] m_axis_tdata;
    logic [1:0]  m_axis_tuser;
    logic        m_axis_tlast;

    longint    mat_shadow [16];
    inv_elem_t inverse_q [$];
    int        error_count;
    int        burst_left;
    int        stall_mode;

    matrix4_inverse_cofactor #(.FRACTION_BITS(FracBits)) dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    always #1 clk = ~clk;

    function automatic longint cofactor_at(int rr, int cc);
        int     rs [3];
        int     cs [3];
        int     n;
        longint d;
        n = 0;
        for (int k = 0; k < 4; k++)
            if (k != rr)
            begin
                rs[n] = k;
                n++;
            end
        n = 0;
        for (int k = 0; k < 4; k++)
            if (k != cc)
            begin
                cs[n] = k;
                n++;
            end
        d = mat_shadow[rs[0]*4+cs[0]] * (mat_shadow[rs[1]*4+cs[1]] * mat_shadow[rs[2]*4+cs[2]]
              - mat_shadow[rs[1]*4+cs[2]] * mat_shadow[rs[2]*4+cs[1]])
          - mat_shadow[rs[0]*4+cs[1]] * (mat_shadow[rs[1]*4+cs[0]] * mat_shadow[rs[2]*4+cs[2]]
              - mat_shadow[rs[1]*4+cs[2]] * mat_shadow[rs[2]*4+cs[0]])
          + mat_shadow[rs[0]*4+cs[2]] * (mat_shadow[rs[1]*4+cs[0]] * mat_shadow[rs[2]*4+cs[1]]
              - mat_shadow[rs[1]*4+cs[1]] * mat_shadow[rs[2]*4+cs[0]]);
        return ((rr + cc) % 2) ? -d : d;
    endfunction

    task automatic predict_inverse(logic [3:0] idx, logic [14:0] raw);
        longint       adj [16];
        longint       det;
        logic [127:0] nm;
        logic [127:0] dm;
        logic [127:0] q;
        logic         neg;
        inv_elem_t    e;
        mat_shadow[idx] = longint'(elem_t'(raw));
        if (idx != LastIdx)
            return;
        for (int r = 0; r < 4; r++)
            for (int c = 0; c < 4; c++)
                adj[r*4+c] = cofactor_at(c, r);
        det = mat_shadow[0]*adj[0] + mat_shadow[1]*adj[4]
            + mat_shadow[2]*adj[8] + mat_shadow[3]*adj[12];
        if (det == 0)
        begin
            e = '{idx: 4'd0, value: 32'd0, singular: 1'b1, saturated: 1'b0, last: 1'b1};
            inverse_q = {inverse_q, e};
            return;
        end
        dm = (det < 0) ? 128'(-det) : 128'(det);
        for (int k = 0; k < 16; k++)
        begin
            nm  = (adj[k] < 0) ? 128'(-adj[k]) : 128'(adj[k]);
            nm  = nm << (2 * FracBits);
            q   = nm / dm;
            neg = (adj[k] < 0) != (det < 0);
            e.idx       = k[3:0];
            e.singular  = 1'b0;
            e.last      = (k == LastIdx);
            e.saturated = 1'b0;
            if (!neg)
            begin
                if (q > 128'h7FFF_FFFF)
                begin
                    e.saturated = 1'b1;
                    e.value     = 32'h7FFF_FFFF;
                end
                else
                    e.value = q[31:0];
            end
            else
            begin
                if (q > 128'h8000_0000)
                begin
                    e.saturated = 1'b1;
                    e.value     = 32'h8000_0000;
                end
                else
                    e.value = -q[31:0];
            end
            inverse_q = {inverse_q, e};
        end
    endtask

    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        $display("MISMATCH %s: got %h expected %h at %0t", what, got, want, $realtime);
        error_count++;
    endtask

    task automatic send_element(logic [3:0] idx, logic [14:0] value);
        int gap;
        if (burst_left == 0)
        begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            if (gap > 0)
            begin
                s_axis_tvalid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = $urandom_range(1, 20);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {5'd0, value, idx};
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        predict_inverse(idx, value);
        burst_left--;
    endtask

    task automatic wait_drain();
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
        while (inverse_q.size() != 0)
            @(posedge clk);
    endtask

    function automatic logic [14:0] rand_value();
        case ($urandom_range(0, 3))
            0: return 15'($signed($urandom_range(0, 4096)) - 2048);
            1: return $urandom_range(0, 1) ? 15'h3FFF : 15'h4000;
            default: return 15'($urandom);
        endcase
    endfunction

    task automatic test_singular_zero();
        send_element(4'd15, 15'd0);
    endtask

    task automatic test_identity();
        send_element(4'd0, 15'd1024);
        send_element(4'd5, 15'd1024);
        send_element(4'd10, 15'd1024);
        send_element(4'd15, 15'd1024);
    endtask

    task automatic test_saturation();
        // unit diagonal with one huge off-diagonal term clips the inverse
        send_element(4'd0, 15'd1);
        send_element(4'd5, 15'd1);
        send_element(4'd10, 15'd1);
        send_element(4'd1, 15'h3FFF);
        send_element(4'd15, 15'd1);
        send_element(4'd1, 15'h4000);
        send_element(4'd15, 15'd1);
    endtask

    task automatic test_extremes();
        send_element(4'd0, 15'h4000);
        send_element(4'd1, 15'd0);
        send_element(4'd5, 15'h3FFF);
        send_element(4'd10, 15'h4000);
        send_element(4'd15, 15'h3FFF);
        send_element(4'd15, 15'h7FFF);
    endtask

    task automatic test_random_matrices();
        int order [16];
        int sent;
        int j;
        int t;
        sent = 0;
        while (sent < 132)
        begin
            if ($urandom_range(0, 5) == 0)
            begin
                send_element(4'($urandom), rand_value());
                sent++;
            end
            else
            begin
                for (int k = 0; k < 16; k++)
                    order[k] = k;
                for (int k = 14; k > 0; k--)
                begin
                    j = $urandom_range(0, k);
                    t = order[k];
                    order[k] = order[j];
                    order[j] = t;
                end
                for (int k = 0; k < 16; k++)
                begin
                    // short vectors keep values small but nonsingular most of the time
                    if ($urandom_range(0, 2) == 0)
                        send_element(4'(order[k]), 15'($signed($urandom_range(0, 64)) - 32));
                    else
                        send_element(4'(order[k]), rand_value());
                end
                sent += 16;
            end
            if (sent > 70 && sent < 90)
                wait_drain();
        end
    endtask

    always @(posedge clk)
    begin
        if (stall_mode == 0)
            m_axis_tready <= 1'b1;
        else if (stall_mode == 1)
            m_axis_tready <= $urandom_range(0, 1);
        else
            m_axis_tready <= ($urandom_range(0, 7) == 0);
        if ($urandom_range(0, 299) == 0)
            stall_mode <= $urandom_range(0, 2);
    end

    task automatic inverse_elem_check();
        inv_elem_t e;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (inverse_q.size() == 0)
            begin
                report_mismatch("unexpected item", m_axis_tdata[35:4], 32'd0);
                return;
            end
            e = inverse_q.pop_front();
            if (m_axis_tdata[3:0] != e.idx)
                report_mismatch("out_index", 32'(m_axis_tdata[3:0]), 32'(e.idx));
            if (m_axis_tdata[35:4] != e.value)
                report_mismatch("out_value", m_axis_tdata[35:4], e.value);
            if (m_axis_tdata[39:36] != 4'd0)
                report_mismatch("tdata pad", 32'(m_axis_tdata[39:36]), 32'd0);
            if (m_axis_tuser[0] != e.singular)
                report_mismatch("singular", 32'(m_axis_tuser[0]), 32'(e.singular));
            if (m_axis_tuser[1] != e.saturated)
                report_mismatch("saturated", 32'(m_axis_tuser[1]), 32'(e.saturated));
            if (m_axis_tlast != e.last)
                report_mismatch("last", 32'(m_axis_tlast), 32'(e.last));
        end
    endtask

    always @(posedge clk)
    begin
        inverse_elem_check();
    end

    initial
    begin
        #2_000_000;
        $display("Test completed with failures");
        $finish;
    end

    initial
    begin
        clk           = 1'b0;
        rst_n         = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        m_axis_tready = 1'b0;
        stall_mode    = 0;
        error_count   = 0;
        burst_left    = 0;
        for (int k = 0; k < 16; k++)
            mat_shadow[k] = 0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_singular_zero();
        test_identity();
        test_saturation();
        test_extremes();
        test_random_matrices();
        wait_drain();
        repeat (200) @(posedge clk);
        if (error_count == 0 && inverse_q.size() == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end
endmodule
